>>> hw/rtl/pplr_pkg.sv
// Shared types and constants for the page pool lookup and replacement block.
package pplr_pkg;

    localparam int NUM_PAGES = 8;
    localparam int PW = 3;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [31:0] BLK_BYTES_RST = 32'd4096;

    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_PREPARE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MIN,
        ST_TIE,
        ST_APPLY,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic find_min;
        logic pick_tie;
        logic apply;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic op_alloc;
        logic free_found;
    } t_sts;

    typedef struct packed {
        logic        status;
        logic [2:0]  page_index;
        logic [63:0] page_base;
        logic [32:0] page_length;
        logic [1:0]  page_blocks;
        logic [31:0] page_usage;
    } t_result;

endpackage

>>> hw/rtl/page_pool_lookup_and_replacement_top.sv
// Top level of the page pool lookup and replacement block.
// One operation in flight at a time: the result becomes valid after the scan and
// update steps that follow the input transfer for lookup, release, prepare and
// an allocate that finds an empty page; an allocate that finds no empty page
// also passes the minimum and tie-pick steps over the 8 pages. The result
// is held until its transfer, and the next input is taken the cycle after, so the
// block takes no new item before the last result has been transferred.
// Page indexes are 3 bits wide, so release and prepare always name a page.
module page_pool_lookup_and_replacement_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_data,     // bytes per block
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // opcode[1:0] position[65:2] page[68:66] cnt[76:69]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // status[0] index[3:1] base[67:4] len[100:68]
                                         // blocks[102:101] usage[134:103]
);

    pplr_pkg::t_cmd    cmd;
    pplr_pkg::t_sts    sts;
    pplr_pkg::t_result res;

    pplr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pplr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (s_axis_tdata[1:0]),
        .i_position    (s_axis_tdata[65:2]),
        .i_page        (s_axis_tdata[68:66]),
        .i_block_count (s_axis_tdata[76:69]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result      (res)
    );

    assign m_axis_tdata = {1'b0, res.page_usage, res.page_blocks, res.page_length,
                           res.page_base, res.page_index, res.status};

    // Only one step command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd)) else $error("multiple commands");
    // No input taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("overlap");
    // Not-found results carry zero page data
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status) |-> (res.page_usage == '0))
        else $error("not found with data");

endmodule

>>> hw/rtl/pplr_ctrl.sv
// Controller state machine sequencing one operation through the datapath.
module pplr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pplr_pkg::t_sts  i_sts,
    output pplr_pkg::t_cmd  o_cmd
);

    pplr_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pplr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pplr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pplr_pkg::ST_SCAN;
                end
            end
            pplr_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.op_alloc && !i_sts.free_found) begin
                    n_state = pplr_pkg::ST_MIN;
                end else begin
                    n_state = pplr_pkg::ST_APPLY;
                end
            end
            pplr_pkg::ST_MIN: begin
                o_cmd.find_min = 1'b1;
                n_state        = pplr_pkg::ST_TIE;
            end
            pplr_pkg::ST_TIE: begin
                o_cmd.pick_tie = 1'b1;
                n_state        = pplr_pkg::ST_APPLY;
            end
            pplr_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = pplr_pkg::ST_OUT;
            end
            pplr_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = pplr_pkg::ST_IDLE;
                end
            end
            default: n_state = pplr_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/pplr_dp.sv
// Datapath: page table registers, scan, minimum search, tie pick and update.
module pplr_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    input  logic [1:0]        i_opcode,
    input  logic [63:0]       i_position,
    input  logic [2:0]        i_page,
    input  logic [7:0]        i_block_count,
    input  pplr_pkg::t_cmd    i_cmd,
    output pplr_pkg::t_sts    o_sts,
    output pplr_pkg::t_result o_result
);

    localparam int N = pplr_pkg::NUM_PAGES;
    localparam int PW = pplr_pkg::PW;

    logic [31:0] r_block_size;
    logic [N-1:0] r_valid, r_wr;
    logic [63:0] r_base [N];
    logic [32:0] r_len [N];
    logic [31:0] r_rd [N];
    logic [31:0] r_use [N];
    logic [1:0]  r_blk [N];
    logic [3:0]  r_tie;

    // Latched request
    pplr_pkg::t_op r_op;
    logic [63:0] r_pos;
    logic [2:0]  r_pg;
    logic [7:0]  r_cnt;

    // Scan results
    logic        r_found;
    logic [PW-1:0] r_pick;
    logic [N-1:0] r_aging;
    logic [31:0] r_min;
    logic [N-1:0] r_cand;
    logic        r_do_tie_wr;
    logic [3:0]  r_tie_next;
    logic [32:0] r_prod;

    // Combinational scan of the table
    logic [N-1:0] hit_v, free_v, cand_v, tie_v;
    logic         hit_any, free_any;
    logic [PW-1:0] hit_idx, free_idx;
    logic [N-1:0] age_v;
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        age_v    = '0;
        for (int i = 0; i < N; i++) begin
            hit_v[i]  = r_valid[i] && !r_wr[i] && (r_pos >= r_base[i]) &&
                        ((r_pos - r_base[i]) < {31'd0, r_len[i]});
            free_v[i] = !r_valid[i] && !r_wr[i];
            cand_v[i] = r_valid[i] && !r_wr[i] && (r_rd[i] == '0);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (hit_v[i]) begin
                hit_any = 1'b1;
                hit_idx = PW'(i);
            end
            if (free_v[i]) begin
                free_any = 1'b1;
                free_idx = PW'(i);
            end
        end
        for (int i = 0; i < N; i++) begin
            age_v[i] = (!free_any || (PW'(i) < free_idx)) && (r_use[i] > 32'd1);
        end
    end

    // Minimum usage over candidates, taken on the aged counts
    logic [31:0] min_c;
    logic [31:0] aged_c;
    always_comb begin
        min_c  = pplr_pkg::SAT32;
        aged_c = '0;
        for (int i = 0; i < N; i++) begin
            aged_c = r_aging[i] ? (r_use[i] - 32'd1) : r_use[i];
            if (cand_v[i] && aged_c < min_c) min_c = aged_c;
        end
    end

    // Tie list selection
    logic [3:0] tie_n;
    logic [3:0] tie_sel;
    logic [PW-1:0] tie_idx;
    logic       tie_hit;
    always_comb begin
        tie_n   = '0;
        tie_idx = '0;
        tie_hit = 1'b0;
        for (int i = 0; i < N; i++) begin
            tie_v[i] = r_cand[i] && (r_use[i] == r_min);
            tie_n    = tie_n + {3'd0, tie_v[i]};
        end
        tie_sel = (r_tie >= tie_n) ? 4'd0 : r_tie;
        begin
            logic [3:0] k;
            k = '0;
            for (int i = 0; i < N; i++) begin
                if (tie_v[i]) begin
                    if (k == tie_sel && !tie_hit) begin
                        tie_hit = 1'b1;
                        tie_idx = PW'(i);
                    end
                    k = k + 4'd1;
                end
            end
        end
    end

    assign o_sts.op_alloc   = (r_op == pplr_pkg::OP_ALLOCATE);
    assign o_sts.free_found = free_any;

    logic [1:0] blocks;
    assign blocks = (r_cnt > 8'd2) ? 2'd2 : r_cnt[1:0];

    // Page length: blocks is at most two, so a shift and a select do
    logic [32:0] len_c;
    always_comb begin
        case (blocks)
            2'd2:    len_c = {r_block_size, 1'b0};
            2'd1:    len_c = {1'b0, r_block_size};
            default: len_c = '0;
        endcase
    end

    // Sequenced updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= pplr_pkg::BLK_BYTES_RST;
            r_valid      <= '0;
            r_wr         <= '0;
            r_tie        <= '0;
            for (int i = 0; i < N; i++) begin
                r_base[i] <= '0;
                r_len[i]  <= '0;
                r_rd[i]   <= '0;
                r_use[i]  <= '0;
                r_blk[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) r_block_size <= i_cfg_data;
            if (i_cmd.load) begin
                r_op  <= pplr_pkg::t_op'(i_opcode);
                r_pos <= i_position;
                r_pg  <= i_page;
                r_cnt <= i_block_count;
            end
            if (i_cmd.scan) begin
                r_do_tie_wr <= 1'b0;
                r_prod      <= len_c;
                r_aging     <= (r_op == pplr_pkg::OP_ALLOCATE) ? age_v : '0;
                case (r_op)
                    pplr_pkg::OP_LOOKUP: begin
                        r_found <= hit_any;
                        r_pick  <= hit_idx;
                    end
                    pplr_pkg::OP_ALLOCATE: begin
                        r_found <= free_any;
                        r_pick  <= free_idx;
                    end
                    default: begin
                        r_found <= 1'b1;
                        r_pick  <= r_pg;
                    end
                endcase
            end
            if (i_cmd.find_min) begin
                r_min  <= min_c;
                r_cand <= cand_v;
                for (int i = 0; i < N; i++) begin
                    if (r_aging[i]) r_use[i] <= r_use[i] - 32'd1;
                end
                r_aging <= '0;
            end
            if (i_cmd.pick_tie) begin
                if (r_min != pplr_pkg::SAT32 && tie_hit) begin
                    r_found    <= 1'b1;
                    r_pick     <= tie_idx;
                    r_do_tie_wr <= 1'b1;
                    r_tie_next <= tie_sel + 4'd1;
                end
            end
            if (i_cmd.apply) begin
                if (r_do_tie_wr) r_tie <= r_tie_next;
                for (int i = 0; i < N; i++) begin
                    if (r_aging[i] && !(r_found && PW'(i) == r_pick))
                        r_use[i] <= r_use[i] - 32'd1;
                end
                if (r_found) begin
                    case (r_op)
                        pplr_pkg::OP_LOOKUP: begin
                            if (r_rd[r_pick] != pplr_pkg::SAT32)
                                r_rd[r_pick] <= r_rd[r_pick] + 32'd1;
                            if (r_use[r_pick] != pplr_pkg::SAT32)
                                r_use[r_pick] <= r_use[r_pick] + 32'd1;
                        end
                        pplr_pkg::OP_ALLOCATE: begin
                            r_wr[r_pick]  <= 1'b1;
                            r_use[r_pick] <= 32'd1;
                        end
                        pplr_pkg::OP_RELEASE: begin
                            if (r_wr[r_pick]) r_wr[r_pick] <= 1'b0;
                            else if (r_rd[r_pick] != '0)
                                r_rd[r_pick] <= r_rd[r_pick] - 32'd1;
                        end
                        default: begin
                            r_blk[r_pick]   <= blocks;
                            r_len[r_pick]   <= r_prod;
                            r_base[r_pick]  <= r_pos;
                            r_valid[r_pick] <= 1'b1;
                            r_use[r_pick]   <= 32'd1;
                        end
                    endcase
                end
            end
        end
    end

    // Result, read from the table after the update; stable while the result waits
    always_comb begin
        o_result        = '0;
        o_result.status = !r_found;
        if (r_found) begin
            o_result.page_index  = r_pick;
            o_result.page_base   = r_base[r_pick];
            o_result.page_length = r_len[r_pick];
            o_result.page_blocks = r_blk[r_pick];
            o_result.page_usage  = r_use[r_pick];
        end
    end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the page pool lookup and replacement block.
module testbench;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int NP = pplr_pkg::NUM_PAGES;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;

    page_pool_lookup_and_replacement_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the page table
    logic        pg_valid  [NP];
    logic [63:0] pg_base   [NP];
    logic [32:0] pg_len    [NP];
    logic        pg_wr     [NP];
    logic [31:0] pg_readers[NP];
    logic [31:0] pg_usage  [NP];
    logic [1:0]  pg_blocks [NP];
    int unsigned rr_ptr;
    logic [31:0] blk_size;

    pplr_pkg::t_result pending_results[$];
    int          errors = 0;
    int          result_cnt = 0;
    int          op_seen[4] = '{0, 0, 0, 0};
    longint      cycle = 0;

    function automatic pplr_pkg::t_result page_result(int idx);
        pplr_pkg::t_result r;
        r.status      = 1'b0;
        r.page_index  = idx[2:0];
        r.page_base   = pg_base[idx];
        r.page_length = pg_len[idx];
        r.page_blocks = pg_blocks[idx];
        r.page_usage  = pg_usage[idx];
        return r;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < NP; i++) begin
            pg_valid[i] = 0; pg_base[i] = '0; pg_len[i] = '0; pg_wr[i] = 0;
            pg_readers[i] = '0; pg_usage[i] = '0; pg_blocks[i] = '0;
        end
        rr_ptr = 0;
        blk_size = pplr_pkg::BLK_BYTES_RST;
    endfunction

    // Apply one operation to the shadow table and return its result
    function automatic pplr_pkg::t_result page_table_step(pplr_pkg::t_op op,
                                                          logic [63:0] pos,
                                                          logic [2:0] pg,
                                                          logic [7:0] cnt);
        pplr_pkg::t_result miss = '{status: 1'b1, default: '0};
        int          pick = -1;
        logic [31:0] min_use;
        int          ties[$];
        int          p = pg;
        logic [1:0]  nb;
        case (op)
            pplr_pkg::OP_LOOKUP: begin
                for (int i = 0; i < NP; i++) begin
                    if (pick < 0 && pg_valid[i] && !pg_wr[i] && pos >= pg_base[i] &&
                        (pos - pg_base[i]) < {31'd0, pg_len[i]})
                        pick = i;
                end
                if (pick < 0) return miss;
                if (pg_readers[pick] != pplr_pkg::SAT32) pg_readers[pick]++;
                if (pg_usage[pick] != pplr_pkg::SAT32) pg_usage[pick]++;
                return page_result(pick);
            end
            pplr_pkg::OP_ALLOCATE: begin
                // first free page; pages passed over age by one
                for (int i = 0; i < NP && pick < 0; i++) begin
                    if (!pg_valid[i] && !pg_wr[i]) pick = i;
                    else if (pg_usage[i] > 1) pg_usage[i]--;
                end
                if (pick < 0) begin
                    min_use = pplr_pkg::SAT32;
                    for (int i = 0; i < NP; i++)
                        if (pg_valid[i] && !pg_wr[i] && pg_readers[i] == 0 &&
                            pg_usage[i] < min_use)
                            min_use = pg_usage[i];
                    if (min_use == pplr_pkg::SAT32) return miss;
                    for (int i = 0; i < NP; i++)
                        if (pg_valid[i] && !pg_wr[i] && pg_readers[i] == 0 &&
                            pg_usage[i] == min_use)
                            ties.push_back(i);
                    if (rr_ptr >= ties.size()) rr_ptr = 0;
                    pick = ties[rr_ptr];
                    rr_ptr++;
                end
                pg_wr[pick] = 1;
                pg_usage[pick] = 1;
                return page_result(pick);
            end
            pplr_pkg::OP_RELEASE: begin
                if (pg_wr[p]) pg_wr[p] = 0;
                else if (pg_readers[p] > 0) pg_readers[p]--;
                return page_result(p);
            end
            default: begin
                nb = (cnt > 2) ? 2'd2 : cnt[1:0];
                pg_blocks[p] = nb;
                pg_len[p] = 33'(nb) * 33'(blk_size);
                pg_base[p] = pos;
                pg_valid[p] = 1;
                pg_usage[p] = 1;
                return page_result(p);
            end
        endcase
    endfunction

    // Directed stimulus; expected result given only where obvious
    typedef struct {
        pplr_pkg::t_op     op;
        logic [63:0]       pos;
        logic [2:0]        pg;
        logic [7:0]        cnt;
        logic              typed;
        pplr_pkg::t_result exp;
    } t_row;

    t_row directed[$];

    function automatic void add_row(pplr_pkg::t_op op, logic [63:0] pos, logic [2:0] pg,
                                    logic [7:0] cnt);
        directed.push_back('{op, pos, pg, cnt, 1'b0, '0});
    endfunction

    function automatic void add_typed(pplr_pkg::t_op op, logic [63:0] pos, logic [2:0] pg,
                                      logic [7:0] cnt, pplr_pkg::t_result r);
        directed.push_back('{op, pos, pg, cnt, 1'b1, r});
    endfunction

    // Sender: burst/gap pacing, one transfer per call
    int burst_left = 0;

    task automatic send_item(pplr_pkg::t_op op, logic [63:0] pos, logic [2:0] pg,
                             logic [7:0] cnt, logic typed, pplr_pkg::t_result exp);
        pplr_pkg::t_result pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, cnt, pg, pos, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = page_table_step(op, pos, pg, cnt);
        if (typed && pred !== exp)
            $display("%0t: table row disagrees with prediction exp=%h got=%h",
                     $time, exp, pred);
        if (typed && pred !== exp) errors++;
        pending_results.push_back(pred);
        op_seen[op]++;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_block_size(logic [31:0] v);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        blk_size = v;
    endtask

    // Receiver stall pattern: always-ready stretches alternating with random stalls
    always @(posedge i_clk) begin
        if (cycle % 200 < 60) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // Result checker
    always @(posedge i_clk) begin
        pplr_pkg::t_result got, want;
        cycle <= cycle + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status      = m_axis_tdata[0];
            got.page_index  = m_axis_tdata[3:1];
            got.page_base   = m_axis_tdata[67:4];
            got.page_length = m_axis_tdata[100:68];
            got.page_blocks = m_axis_tdata[102:101];
            got.page_usage  = m_axis_tdata[134:103];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                result_cnt++;
                if (got.status !== want.status || got.page_index !== want.page_index ||
                    got.page_base !== want.page_base ||
                    got.page_length !== want.page_length ||
                    got.page_blocks !== want.page_blocks ||
                    got.page_usage !== want.page_usage) begin
                    $display("%0t: result mismatch expected=%h actual=%h",
                             $time, want, got);
                    errors++;
                end
            end
        end
        if (cycle > LIMIT_CYCLES) begin
            $display("page_pool_lookup_and_replacement_top regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random content, mostly well-formed: prepare pages then look inside them
    task automatic random_item();
        int          k = $urandom_range(0, 99);
        logic [2:0]  p = 3'($urandom_range(0, 7));
        logic [63:0] pos;
        if (k < 30) begin
            pos = pg_base[p] + (pg_len[p] == 0 ? 64'd0 : {$urandom(), $urandom()} % pg_len[p]);
            if ($urandom_range(0, 4) == 0) pos = pg_base[p] + pg_len[p];
            if ($urandom_range(0, 6) == 0) pos = rand64();
            send_item(pplr_pkg::OP_LOOKUP, pos, p, 8'($urandom()), 1'b0, '0);
        end else if (k < 50) begin
            send_item(pplr_pkg::OP_ALLOCATE, rand64(), p, 8'($urandom()), 1'b0, '0);
        end else if (k < 72) begin
            send_item(pplr_pkg::OP_RELEASE, rand64(), p, 8'($urandom()), 1'b0, '0);
        end else begin
            pos = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 65535));
            send_item(pplr_pkg::OP_PREPARE, pos, p,
                      8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom()),
                      1'b0, '0);
        end
    endtask

    initial begin
        pplr_pkg::t_result miss = '{status: 1'b1, default: '0};
        table_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: empty table misses, first allocate takes page 0
        add_typed(pplr_pkg::OP_LOOKUP, 64'd0, 3'd0, 8'd0, miss);
        add_typed(pplr_pkg::OP_ALLOCATE, '0, 3'd0, 8'd0,
                  '{1'b0, 3'd0, 64'd0, 33'd0, 2'd0, 32'd1});
        add_typed(pplr_pkg::OP_RELEASE, '1, 3'd0, 8'hFF,
                  '{1'b0, 3'd0, 64'd0, 33'd0, 2'd0, 32'd1});
        add_typed(pplr_pkg::OP_PREPARE, '1, 3'd7, 8'hFF,
                  '{1'b0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 33'd8192, 2'd2, 32'd1});
        add_row(pplr_pkg::OP_PREPARE, 64'd0, 3'd1, 8'd1);
        add_row(pplr_pkg::OP_PREPARE, 64'd4096, 3'd2, 8'd0);
        add_row(pplr_pkg::OP_LOOKUP, 64'd4095, 3'd0, 8'd0);
        add_row(pplr_pkg::OP_LOOKUP, 64'd4096, 3'd0, 8'd0);
        add_row(pplr_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 8'd0);
        add_row(pplr_pkg::OP_RELEASE, 64'd0, 3'd1, 8'd0);
        add_row(pplr_pkg::OP_RELEASE, 64'd0, 3'd1, 8'd0);
        for (int i = 0; i < 8; i++)
            add_row(pplr_pkg::OP_PREPARE, 64'(i) << 16, 3'(i), 8'd2);
        for (int i = 0; i < 3; i++) add_row(pplr_pkg::OP_ALLOCATE, '0, 3'd0, 8'd0);
        add_row(pplr_pkg::OP_LOOKUP, 64'h1_0000, 3'd0, 8'd0);
        foreach (directed[i])
            send_item(directed[i].op, directed[i].pos, directed[i].pg, directed[i].cnt,
                      directed[i].typed, directed[i].exp);

        // random phases over several block sizes, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_block_size(32'd0);
                1: write_block_size(32'hFFFF_FFFF);
                2: write_block_size(32'd1);
                3: write_block_size($urandom());
                default: write_block_size(32'd512);
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) random_item();
        end

        wait_drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d lookups, %0d allocates, %0d releases, %0d prepares;",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("%0d results checked across 6 block size settings", result_cnt);
        if (errors == 0 && pending_results.size() == 0)
            $display("page_pool_lookup_and_replacement_top regression: pass");
        else
            $display("page_pool_lookup_and_replacement_top regression: fail");
        $finish;
    end
endmodule
